/* rtl/core/kpet_pkg.sv */
// Package: shared types and constants for the keyed pass enable table.
`timescale 1ns / 1ps
package kpet_pkg;
    localparam int MaxEntries  = 32;
    localparam int MaxBindings = 8;
    localparam int EIdxW = $clog2(MaxEntries);
    localparam int ECntW = $clog2(MaxEntries + 1);
    localparam int BIdxW = (MaxBindings > 1) ? $clog2(MaxBindings) : 1;
    localparam int BCntW = $clog2(MaxBindings + 1);

    typedef enum logic [2:0] {
        OP_REGISTER = 3'd0, OP_QUERY = 3'd1, OP_SET = 3'd2, OP_RESET = 3'd3,
        OP_FIND = 3'd4, OP_DECL_RD = 3'd5, OP_DECL_WR = 3'd6, OP_VALIDATE = 3'd7
    } t_op;

    typedef enum logic [2:0] {
        ST_OK = 3'd0, ST_FULL = 3'd1, ST_DUP = 3'd2, ST_NOTFOUND = 3'd3,
        ST_BINDFULL = 3'd4, ST_ORDER = 3'd5
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE, S_SEARCH, S_EXEC, S_RESET, S_VP, S_VRD, S_VRW, S_VW, S_VWW, S_DONE
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;       // capture transaction
        logic ptr_clr;    // clear entry pointer p
        logic ptr_inc;    // advance p
        logic bptr_clr;   // clear binding pointer b
        logic bptr_inc;   // advance b
        logic wptr_clr;   // clear writer pointer w and writer binding pointer
        logic wptr_inc;   // advance writer entry
        logic wbptr_inc;  // advance writer binding
        logic exec;       // apply the op
        logic rst_step;   // restore enable bit at p
        logic rd_rkey;    // issue read of read_keys[p][b]
        logic rd_wkey;    // issue read of write_keys[w][wb]
        logic cap_res;    // capture read-key data as current resource
        logic clr_lw;     // clear latest writer
        logic upd_lw;     // compare write-key data, update latest writer
        logic set_viol;
        logic set_out;    // load output register
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        t_op  op;
        logic hit;        // entry at p matches key
        logic p_end;      // p has reached entry_count
        logic b_end;      // b has reached read count of p
        logic w_end;
        logic wb_end;
        logic viol;
    } t_sts;
endpackage

/* rtl/core/kpet_datapath.sv */
// Datapath: entry registers, binding memories, pointers and result register.
`timescale 1ns / 1ps
module kpet_datapath import kpet_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  logic [2:0]  i_op,
    input  logic [31:0] i_pass_key,
    input  logic        i_flag_value,
    input  logic [31:0] i_resource_key,
    output t_sts        o_sts,
    output logic [2:0]  o_status,
    output logic        o_enabled,
    output logic [4:0]  o_entry_index
);
    logic [31:0]      r_keys [MaxEntries];
    logic [MaxEntries-1:0] r_en, r_def;
    logic [ECntW-1:0] r_count;
    logic [BCntW-1:0] r_rcnt [MaxEntries];
    logic [BCntW-1:0] r_wcnt [MaxEntries];
    logic [31:0]      r_rmem [MaxEntries*MaxBindings];
    logic [31:0]      r_wmem [MaxEntries*MaxBindings];
    logic [31:0]      r_rdata, r_wdata, r_res;

    t_op              r_op;
    logic [31:0]      r_key, r_rkey;
    logic             r_flag;
    logic [ECntW-1:0] r_p, r_w;
    logic [BCntW-1:0] r_b, r_wb;
    logic             r_lw_ok;     // a writer was seen
    logic [EIdxW-1:0] r_lw;
    logic             r_viol;
    logic [2:0]       r_status;
    logic             r_enabled;
    logic [4:0]       r_idx;

    logic [EIdxW-1:0] pi, wi;
    logic             found;
    logic [EIdxW-1:0] fi;
    assign pi = r_p[EIdxW-1:0];
    assign wi = r_w[EIdxW-1:0];
    // search stops on a hit, so p holds the match index
    assign found = (r_p != r_count);
    assign fi = pi;

    assign o_sts.op     = r_op;
    assign o_sts.hit    = (r_p != r_count) && (r_keys[pi] == r_key);
    assign o_sts.p_end  = (r_p == r_count);
    assign o_sts.b_end  = (r_b == r_rcnt[pi]);
    assign o_sts.w_end  = (r_w == r_count);
    assign o_sts.wb_end = (r_wb == r_wcnt[wi]);
    assign o_sts.viol   = r_viol;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= t_op'(i_op);
            r_key  <= i_pass_key;
            r_flag <= i_flag_value;
            r_rkey <= i_resource_key;
        end
        if (i_cmd.rd_rkey) r_rdata <= r_rmem[{pi, r_b[BIdxW-1:0]}];
        if (i_cmd.rd_wkey) r_wdata <= r_wmem[{wi, r_wb[BIdxW-1:0]}];
        if (i_cmd.cap_res) r_res <= r_rdata;
        if (i_cmd.exec && found) begin
            if (r_op == OP_DECL_RD && r_rcnt[fi] != BCntW'(MaxBindings))
                r_rmem[{fi, r_rcnt[fi][BIdxW-1:0]}] <= r_rkey;
            if (r_op == OP_DECL_WR && r_wcnt[fi] != BCntW'(MaxBindings))
                r_wmem[{fi, r_wcnt[fi][BIdxW-1:0]}] <= r_rkey;
        end
        if (i_cmd.exec && r_op == OP_REGISTER && r_count != ECntW'(MaxEntries) && !found)
            r_keys[r_count[EIdxW-1:0]] <= r_key;
        if (i_cmd.exec && r_op == OP_REGISTER && r_count != ECntW'(MaxEntries) && !found)
            r_def[r_count[EIdxW-1:0]] <= r_flag;
        if (i_cmd.exec && r_op == OP_REGISTER && r_count != ECntW'(MaxEntries) && !found)
            r_en[r_count[EIdxW-1:0]] <= r_flag;
        else if (i_cmd.exec && r_op == OP_SET && found)
            r_en[fi] <= r_flag;
        else if (i_cmd.rst_step)
            r_en[pi] <= r_def[pi];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            for (int i = 0; i < MaxEntries; i++) begin
                r_rcnt[i] <= '0;
                r_wcnt[i] <= '0;
            end
            r_p <= '0; r_b <= '0; r_w <= '0; r_wb <= '0;
            r_lw_ok <= 1'b0; r_lw <= '0; r_viol <= 1'b0;
            r_status <= '0; r_enabled <= 1'b0; r_idx <= '0;
        end else begin
            if (i_cmd.ptr_clr) r_p <= '0;
            else if (i_cmd.ptr_inc) r_p <= r_p + 1'b1;
            if (i_cmd.bptr_clr) r_b <= '0;
            else if (i_cmd.bptr_inc) r_b <= r_b + 1'b1;
            if (i_cmd.wptr_clr) begin
                r_w <= '0; r_wb <= '0;
            end else if (i_cmd.wptr_inc) begin
                r_w <= r_w + 1'b1; r_wb <= '0;
            end else if (i_cmd.wbptr_inc) r_wb <= r_wb + 1'b1;
            if (i_cmd.clr_lw) r_lw_ok <= 1'b0;
            else if (i_cmd.upd_lw && r_wdata == r_res) begin
                r_lw_ok <= 1'b1; r_lw <= wi;
            end
            if (i_cmd.load) r_viol <= 1'b0;
            else if (i_cmd.set_viol && r_lw_ok && r_lw >= pi) r_viol <= 1'b1;
            if (i_cmd.exec) begin
                if (r_op == OP_REGISTER && r_count != ECntW'(MaxEntries) && !found) begin
                    r_rcnt[r_count[EIdxW-1:0]] <= '0;
                    r_wcnt[r_count[EIdxW-1:0]] <= '0;
                    r_count <= r_count + 1'b1;
                end
                if (found && r_op == OP_DECL_RD && r_rcnt[fi] != BCntW'(MaxBindings))
                    r_rcnt[fi] <= r_rcnt[fi] + 1'b1;
                if (found && r_op == OP_DECL_WR && r_wcnt[fi] != BCntW'(MaxBindings))
                    r_wcnt[fi] <= r_wcnt[fi] + 1'b1;
            end
            if (i_cmd.set_out) begin
                r_status <= ST_OK; r_enabled <= 1'b0; r_idx <= '0;
                case (r_op)
                    OP_REGISTER: begin
                        if (r_count == ECntW'(MaxEntries)) r_status <= ST_FULL;
                        else if (found) r_status <= ST_DUP;
                        else r_idx <= 5'(r_count);
                    end
                    OP_QUERY: begin
                        if (!found) begin
                            r_status <= ST_NOTFOUND; r_enabled <= 1'b1;
                        end else begin
                            r_idx <= 5'(fi); r_enabled <= r_en[fi];
                        end
                    end
                    OP_SET, OP_FIND: begin
                        if (!found) r_status <= ST_NOTFOUND;
                        else r_idx <= 5'(fi);
                    end
                    OP_DECL_RD: begin
                        if (!found) r_status <= ST_NOTFOUND;
                        else if (r_rcnt[fi] == BCntW'(MaxBindings)) r_status <= ST_BINDFULL;
                        else r_idx <= 5'(fi);
                    end
                    OP_DECL_WR: begin
                        if (!found) r_status <= ST_NOTFOUND;
                        else if (r_wcnt[fi] == BCntW'(MaxBindings)) r_status <= ST_BINDFULL;
                        else r_idx <= 5'(fi);
                    end
                    OP_VALIDATE: if (r_viol) r_status <= ST_ORDER;
                    default: ;
                endcase
            end
        end
    end

    assign o_status      = r_status;
    assign o_enabled     = r_enabled;
    assign o_entry_index = r_idx;
endmodule

/* rtl/core/kpet_ctrl.sv */
// Controller: sequences search, update, reset sweep and ordering check.
`timescale 1ns / 1ps
module kpet_ctrl import kpet_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    output logic o_valid,
    input  logic i_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);
    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        o_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load = 1'b1; o_cmd.ptr_clr = 1'b1; o_cmd.bptr_clr = 1'b1;
                    n_state = S_SEARCH;
                end
            end
            S_SEARCH: begin
                if (i_sts.op == OP_RESET) n_state = S_RESET;
                else if (i_sts.op == OP_VALIDATE) n_state = S_VP;
                else if (i_sts.p_end || i_sts.hit) n_state = S_EXEC;
                else o_cmd.ptr_inc = 1'b1;
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1; o_cmd.set_out = 1'b1;
                n_state = S_DONE;
            end
            S_RESET: begin
                if (i_sts.p_end) begin
                    o_cmd.set_out = 1'b1; n_state = S_DONE;
                end else begin
                    o_cmd.rst_step = 1'b1; o_cmd.ptr_inc = 1'b1;
                end
            end
            // walk each read binding of entry p
            S_VP: begin
                if (i_sts.p_end || i_sts.viol) begin
                    o_cmd.set_out = 1'b1; n_state = S_DONE;
                end else if (i_sts.b_end) begin
                    o_cmd.ptr_inc = 1'b1; o_cmd.bptr_clr = 1'b1;
                end else begin
                    o_cmd.rd_rkey = 1'b1; n_state = S_VRD;
                end
            end
            S_VRD: begin
                o_cmd.cap_res = 1'b1; o_cmd.clr_lw = 1'b1; o_cmd.wptr_clr = 1'b1;
                n_state = S_VW;
            end
            // scan all write bindings for the latest writer of the resource
            S_VW: begin
                if (i_sts.w_end) begin
                    o_cmd.set_viol = 1'b1; o_cmd.bptr_inc = 1'b1;
                    n_state = S_VRW;
                end else if (i_sts.wb_end) o_cmd.wptr_inc = 1'b1;
                else begin
                    o_cmd.rd_wkey = 1'b1; n_state = S_VWW;
                end
            end
            S_VWW: begin
                o_cmd.upd_lw = 1'b1; o_cmd.wbptr_inc = 1'b1;
                n_state = S_VW;
            end
            S_VRW: n_state = S_VP;
            S_DONE: begin
                o_valid = 1'b1;
                if (i_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule

/* rtl/core/keyed_pass_enable_table.sv */
// Top level: keyed pass enable table, one transaction in flight at a time.
`timescale 1ns / 1ps
// Takes one transaction at a time. Register, query, set, find and declare
// scan entries one per cycle (up to 32); reset walks all entries. Validate
// reads each read binding and, for each one, scans every write binding of
// every entry through the binding memories to find its latest writer, then
// steps past each entry's read list; it stops at the first ordering
// violation. The result is held in an output register until taken; the next
// transaction is accepted after.
module keyed_pass_enable_table import kpet_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_op,
    input  logic [31:0] i_pass_key,
    input  logic        i_flag_value,
    input  logic [31:0] i_resource_key,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_status,
    output logic        o_enabled,
    output logic [4:0]  o_entry_index
);
    t_cmd cmd;
    t_sts sts;

    kpet_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .o_valid, .i_ready,
        .i_sts(sts), .o_cmd(cmd)
    );

    kpet_datapath u_dp (
        .i_clk, .i_rst_n, .i_cmd(cmd), .i_op, .i_pass_key, .i_flag_value,
        .i_resource_key, .o_sts(sts), .o_status, .o_enabled, .o_entry_index
    );
endmodule
